// ===== src/spring_damper_force_schedule_defines.svh =====
// Assertion helpers used by the checker module.
`ifndef SPRING_DAMPER_FORCE_SCHEDULE_DEFINES_SVH
`define SPRING_DAMPER_FORCE_SCHEDULE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SDFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sdfs_pkg.sv =====
`default_nettype none
package sdfs_pkg;

  localparam int unsigned TickW = 10;
  localparam logic [TickW-1:0] TickMax     = '1;
  localparam logic [TickW-1:0] Stage1Ticks = 10'd500;
  localparam logic [TickW-1:0] Stage2Ticks = 10'd750;

  localparam int unsigned KW = 11;  // widest stiffness is 2000 N/m

  typedef enum logic [1:0] {
    STAGE_INIT  = 2'd0,
    STAGE_MID   = 2'd1,
    STAGE_FINAL = 2'd2
  } stage_e;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_X   = 2'd1,
    MODE_XY  = 2'd2,
    MODE_ALL = 2'd3
  } axis_mode_e;

  typedef enum logic [2:0] {
    CFG_AXIS_MODE = 3'd0,
    CFG_CENTER_X  = 3'd1,
    CFG_CENTER_Y  = 3'd2,
    CFG_CENTER_Z  = 3'd3,
    CFG_DAMPING   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] vel_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic [1:0]         gain_stage;
  } out_t;

  // pipeline load strobes for the lane registers
  typedef struct packed {
    logic load_a;
    logic load_b;
  } adv_t;

  function automatic logic [KW-1:0] stiff_x(stage_e s);
    logic [KW-1:0] k;
    case (s)
      STAGE_INIT:  k = 11'd200;
      STAGE_MID:   k = 11'd500;
      STAGE_FINAL: k = 11'd2000;
      default:     k = 11'd2000;
    endcase
    return k;
  endfunction

  function automatic logic [KW-1:0] stiff_yz(stage_e s);
    logic [KW-1:0] k;
    case (s)
      STAGE_INIT:  k = 11'd50;
      STAGE_MID:   k = 11'd250;
      STAGE_FINAL: k = 11'd1500;
      default:     k = 11'd1500;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== src/sdfs_lane.sv =====
`default_nettype none
// One axis: offset, two products, then sum and saturate.
module sdfs_lane (
  input  wire                        clk_i,
  input  wire sdfs_pkg::adv_t        adv_i,
  input  wire logic signed [15:0]    pos_i,
  input  wire logic signed [15:0]    cen_i,
  input  wire logic signed [23:0]    vel_i,
  input  wire logic [sdfs_pkg::KW-1:0] k_i,
  input  wire logic [7:0]            gain_i,
  input  wire logic                  en_i,
  output logic signed [31:0]         force_o
);

  logic signed [16:0] d_q;
  logic signed [23:0] vel_q;
  logic [sdfs_pkg::KW-1:0] k_q;
  logic [7:0]         gain_q;
  logic               en_a_q;

  logic signed [28:0] kd_q;
  logic signed [32:0] cv_q;
  logic               en_b_q;

  logic signed [34:0] sum;
  logic signed [31:0] sat;

  always_ff @(posedge clk_i) begin
    if (adv_i.load_a) begin
      d_q    <= 17'(pos_i) - 17'(cen_i);
      vel_q  <= vel_i;
      k_q    <= k_i;
      gain_q <= gain_i;
      en_a_q <= en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.load_b) begin
      kd_q   <= d_q * $signed({1'b0, k_q});
      cv_q   <= $signed({1'b0, gain_q}) * vel_q;
      en_b_q <= en_a_q;
    end
  end

  always_comb begin
    sum = 35'sd0 - 35'(kd_q) - 35'(cv_q);
    // out of range when the top bits disagree with the sign
    if (sum[34:31] == 4'b0000 || sum[34:31] == 4'b1111) begin
      sat = sum[31:0];
    end else if (sum[34]) begin
      sat = {1'b1, 31'd0};
    end else begin
      sat = {1'b0, {31{1'b1}}};
    end
    force_o = en_b_q ? sat : 32'sd0;
  end

endmodule
`default_nettype wire

// ===== src/sdfs_merge.sv =====
`default_nettype none
// Collects the three lane forces and the stage into the output register.
module sdfs_merge (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire logic               vld_i,
  input  wire logic signed [31:0] force_x_i,
  input  wire logic signed [31:0] force_y_i,
  input  wire logic signed [31:0] force_z_i,
  input  wire sdfs_pkg::stage_e   stage_i,
  input  wire logic               out_stall_i,
  output logic                    ready_o,
  output logic                    out_valid_o,
  output sdfs_pkg::out_t          out_data_o
);

  logic           valid_q, valid_d;
  logic           load;
  sdfs_pkg::out_t data_q;

  assign ready_o = !valid_q || !out_stall_i;
  assign load    = vld_i && ready_o;
  assign valid_d = load || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q.force_x    <= force_x_i;
      data_q.force_y    <= force_y_i;
      data_q.force_z    <= force_z_i;
      data_q.gain_stage <= stage_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
`default_nettype wire

// ===== src/spring_damper_force_schedule.sv =====
// An accepted item passes three register stages (offset, multiply, and
// sum/saturate into the output register), which drives out_valid.
// Throughput: one item per cycle while out_stall is low; the three axis lanes
// run in parallel and each multiply has its own register stage, so no unit is
// shared between items.
// Reset: tick counter to zero, registers to axis_mode 1, centers 0, damping 5,
// pipeline emptied. No clearing pass; items are taken right after reset.
`default_nettype none
module spring_damper_force_schedule (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // input items
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire sdfs_pkg::in_t   in_data_i,
  // result items
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output sdfs_pkg::out_t       out_data_o,
  // configuration writes
  input  wire logic            cfg_we_i,
  input  wire logic [2:0]      cfg_idx_i,
  input  wire logic [15:0]     cfg_data_i
);

  // ---------------- configuration registers ----------------
  sdfs_pkg::axis_mode_e mode_q;
  logic signed [15:0]   cen_x_q, cen_y_q, cen_z_q;
  logic [7:0]           damp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= sdfs_pkg::MODE_X;
      cen_x_q <= '0;
      cen_y_q <= '0;
      cen_z_q <= '0;
      damp_q  <= 8'd5;
    end else if (cfg_we_i) begin
      case (sdfs_pkg::cfg_idx_e'(cfg_idx_i))
        sdfs_pkg::CFG_AXIS_MODE: mode_q  <= sdfs_pkg::axis_mode_e'(cfg_data_i[1:0]);
        sdfs_pkg::CFG_CENTER_X:  cen_x_q <= cfg_data_i;
        sdfs_pkg::CFG_CENTER_Y:  cen_y_q <= cfg_data_i;
        sdfs_pkg::CFG_CENTER_Z:  cen_z_q <= cfg_data_i;
        sdfs_pkg::CFG_DAMPING:   damp_q  <= cfg_data_i[7:0];
        default: ;  // unused index: write dropped
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // Each stage moves when the one after it is empty or moving, so bubbles
  // collapse and the input keeps flowing while a result waits downstream, until stages a and b fill.
  logic vld_a_q, vld_b_q;
  logic ready_a, ready_b, ready_c;
  logic in_acc;
  sdfs_pkg::adv_t adv;

  assign ready_b    = !vld_b_q || ready_c;
  assign ready_a    = !vld_a_q || ready_b;
  assign in_stall_o = !ready_a;
  assign in_acc     = in_valid_i && ready_a;
  assign adv.load_a = in_acc;
  assign adv.load_b = vld_a_q && ready_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= in_acc || (vld_a_q && !ready_b);
      vld_b_q <= adv.load_b || (vld_b_q && !ready_c);
    end
  end

  // ---------------- stiffness schedule ----------------
  // Stage is chosen from the count before this item bumps it; the counter
  // sticks at full scale so the final stage holds forever.
  logic [sdfs_pkg::TickW-1:0] tick_q;
  sdfs_pkg::stage_e           stage_now, stage_a_q, stage_b_q;
  sdfs_pkg::axis_mode_e       axes;
  logic                       en_x, en_y, en_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else if (in_acc && tick_q != sdfs_pkg::TickMax) begin
      tick_q <= tick_q + 1'b1;
    end
  end

  always_comb begin
    if (tick_q <= sdfs_pkg::Stage1Ticks) begin
      stage_now = sdfs_pkg::STAGE_INIT;
    end else if (tick_q <= sdfs_pkg::Stage2Ticks) begin
      stage_now = sdfs_pkg::STAGE_MID;
    end else begin
      stage_now = sdfs_pkg::STAGE_FINAL;
    end
    // centering phase drives every axis regardless of the mode
    axes = (tick_q < sdfs_pkg::Stage2Ticks) ? sdfs_pkg::MODE_ALL : mode_q;
    en_x = (axes != sdfs_pkg::MODE_OFF);
    en_y = (axes == sdfs_pkg::MODE_XY) || (axes == sdfs_pkg::MODE_ALL);
    en_z = (axes == sdfs_pkg::MODE_ALL);
  end

  // stage tag rides alongside the lanes
  always_ff @(posedge clk_i) begin
    if (adv.load_a) stage_a_q <= stage_now;
    if (adv.load_b) stage_b_q <= stage_a_q;
  end

  // ---------------- axis lanes ----------------
  logic signed [31:0] f_x, f_y, f_z;

  sdfs_lane u_lane_x (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .pos_i   (in_data_i.pos_x),
    .cen_i   (cen_x_q),
    .vel_i   (in_data_i.vel_x),
    .k_i     (sdfs_pkg::stiff_x(stage_now)),
    .gain_i  (damp_q),
    .en_i    (en_x),
    .force_o (f_x)
  );

  sdfs_lane u_lane_y (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .pos_i   (in_data_i.pos_y),
    .cen_i   (cen_y_q),
    .vel_i   (in_data_i.vel_y),
    .k_i     (sdfs_pkg::stiff_yz(stage_now)),
    .gain_i  (damp_q),
    .en_i    (en_y),
    .force_o (f_y)
  );

  sdfs_lane u_lane_z (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .pos_i   (in_data_i.pos_z),
    .cen_i   (cen_z_q),
    .vel_i   (in_data_i.vel_z),
    .k_i     (sdfs_pkg::stiff_yz(stage_now)),
    .gain_i  (damp_q),
    .en_i    (en_z),
    .force_o (f_z)
  );

  // ---------------- merge and output register ----------------
  sdfs_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (vld_b_q),
    .force_x_i   (f_x),
    .force_y_i   (f_y),
    .force_z_i   (f_z),
    .stage_i     (stage_b_q),
    .out_stall_i (out_stall_i),
    .ready_o     (ready_c),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ===== src/sdfs_checker.sv =====
`default_nettype none
`include "spring_damper_force_schedule_defines.svh"
module sdfs_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 out_valid_i,
  input wire                 out_stall_i,
  input wire sdfs_pkg::out_t out_data_i
);

  logic out_acc;
  assign out_acc = out_valid_i && !out_stall_i;

  `SDFS_ASSERT_NXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i && $stable(out_data_i), "stalled result changed")
  `SDFS_ASSERT_IMP(a_stage_range, out_valid_i, out_data_i.gain_stage != 2'd3, "bad gain stage")
  `SDFS_ASSERT_NXT(a_final_sticks, out_acc && out_data_i.gain_stage == 2'd2, !out_valid_i || out_data_i.gain_stage == 2'd2, "left final stage")
  `SDFS_ASSERT_NXT(a_mid_no_back, out_acc && out_data_i.gain_stage == 2'd1, !out_valid_i || out_data_i.gain_stage != 2'd0, "stage went back")

endmodule

bind spring_damper_force_schedule sdfs_checker u_sdfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
`default_nettype wire
